[hw/rtl/bgpr_pkg.sv]
// bar graph page renderer: shared constants, operation and register codes
// and the command word passed from the front end to the divider back end
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bgpr_pkg;

  // geometry of the graph
  localparam int COLUMNS   = 128;
  localparam int PAGE_ROWS = 4;
  localparam int GRAPH_H   = 8 * PAGE_ROWS;
  localparam int H_SHIFT   = $clog2(GRAPH_H);

  // field widths
  localparam int OP_W   = 2;
  localparam int SMP_W  = 8;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;

  // store and counter widths
  localparam int IDX_W = $clog2(COLUMNS);
  localparam int CNT_W = $clog2(COLUMNS + 1);

  // divider: numerator is span scaled by the graph height
  localparam int NUM_W  = SMP_W + H_SHIFT;
  localparam int STEP_W = $clog2(NUM_W + 1);

  // command queue depth
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [SMP_W-1:0] FULL_SCALE_RST = SMP_W'(75);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = CFG_IDX_W'(1);

  // one read command for the back end
  typedef struct packed {
    logic [SMP_W-1:0] span;      // sample minus floor, 0 at or below floor
    logic [SMP_W-1:0] scale;     // scale in use at the time of the read
    logic             draw;      // column loaded and row on the graph
    logic [ROW_W-1:0] row;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/bgpr_if.sv]
// bar graph page renderer: item, result and configuration channels
// depends on bgpr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bgpr_in_if import bgpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SMP_W-1:0] sample;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;

  modport source (output valid, operation, sample, row, column, input ready);
  modport sink   (input valid, operation, sample, row, column, output ready);
endinterface

interface bgpr_out_if import bgpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              scale_valid;

  modport source (output valid, pixel_byte, scale_valid, input ready);
  modport sink   (input valid, pixel_byte, scale_valid, output ready);
endinterface

interface bgpr_cfg_if import bgpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SMP_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/bgpr_front.sv]
// bar graph page renderer front end: configuration registers, sample store,
// sample count and running span maximum; turns read words into commands
// depends on bgpr_pkg and bgpr_if
`timescale 1ns / 1ps
`default_nettype none

module bgpr_front import bgpr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  bgpr_in_if.sink     items,
  bgpr_cfg_if.sink    cfg,
  output logic        q_push,
  output cmd_t        q_cmd,
  input  wire logic   q_full
);

  logic [SMP_W-1:0] floor_value;
  logic [SMP_W-1:0] full_scale;
  logic [CNT_W-1:0] sample_count;
  logic [SMP_W-1:0] span_max;
  logic             rd_pend;

  // captured with a read word
  logic [SMP_W-1:0] rd_data;
  logic [SMP_W-1:0] rd_scale;
  logic             rd_draw;
  logic [ROW_W-1:0] rd_row;

  logic [SMP_W-1:0] sample_store [COLUMNS];

  logic             in_acc;
  logic             store_room;
  logic             smp_above;
  logic [SMP_W-1:0] smp_span;
  logic             col_ok;
  logic             row_ok;

  assign items.ready = !rd_pend;
  assign cfg.ready   = 1'b1;
  assign in_acc      = items.valid && items.ready;

  assign store_room = sample_count < CNT_W'(COLUMNS);
  assign smp_above  = items.sample > floor_value;
  assign smp_span   = items.sample - floor_value;
  assign col_ok     = CNT_W'(items.column) < sample_count;
  assign row_ok     = (ROW_W + 4)'(items.row) < (ROW_W + 4)'(PAGE_ROWS);

  // control state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_value  <= '0;
      full_scale   <= FULL_SCALE_RST;
      sample_count <= '0;
      span_max     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_FLOOR: floor_value <= cfg.data;
          CFG_SCALE: full_scale  <= cfg.data;
          default:   ;
        endcase
      end
      if (q_push) begin
        rd_pend <= 1'b0;
      end
      if (in_acc) begin
        unique case (op_t'(items.operation))
          OP_CLEAR: begin
            sample_count <= '0;
            span_max     <= '0;
          end
          OP_LOAD: begin
            if (store_room) begin
              sample_count <= sample_count + CNT_W'(1);
              if (smp_above && smp_span > span_max) begin
                span_max <= smp_span;
              end
            end
          end
          OP_READ: rd_pend <= 1'b1;
          OP_NONE: ;
        endcase
      end
    end
  end

  // read word capture
  always_ff @(posedge clk) begin
    if (in_acc && op_t'(items.operation) == OP_READ) begin
      rd_scale <= (full_scale != '0) ? full_scale : span_max;
      rd_draw  <= col_ok && row_ok;
      rd_row   <= items.row;
    end
  end

  // sample store, one write and one registered read
  always_ff @(posedge clk) begin
    if (in_acc && op_t'(items.operation) == OP_LOAD && store_room) begin
      sample_store[sample_count[IDX_W-1:0]] <= items.sample;
    end
    if (in_acc && op_t'(items.operation) == OP_READ) begin
      rd_data <= sample_store[IDX_W'(items.column)];
    end
  end

  // command towards the back end
  assign q_push      = rd_pend && !q_full;
  assign q_cmd.span  = (rd_draw && rd_data > floor_value) ? rd_data - floor_value : '0;
  assign q_cmd.scale = rd_scale;
  assign q_cmd.draw  = rd_draw;
  assign q_cmd.row   = rd_row;

endmodule

`default_nettype wire

[hw/rtl/bgpr_queue.sv]
// bar graph page renderer: short command queue between front and back end
// depends on bgpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgpr_queue import bgpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t              entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(Q_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bgpr_back.sv]
// bar graph page renderer back end: serial divider for the bar height,
// page byte forming and the result register
// depends on bgpr_pkg and bgpr_if
`timescale 1ns / 1ps
`default_nettype none

module bgpr_back import bgpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t q_head,
  input  wire logic q_empty,
  output logic      q_pop,
  bgpr_out_if.source results
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  num;
  logic [SMP_W-1:0]  rem;
  logic [SMP_W-1:0]  scale;
  logic              draw;
  logic [ROW_W-1:0]  row;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_scale_ok;

  logic [SMP_W:0]    trial;
  logic              ge;
  logic [SMP_W-1:0]  height;
  logic [SMP_W-1:0]  base;
  logic [SMP_W-1:0]  above;
  logic [3:0]        npix;
  logic [BYTE_W-1:0] byte_val;
  logic              load_out;

  // one restoring step per cycle
  assign trial = {rem, num[NUM_W-1]};
  assign ge    = trial >= {1'b0, scale};

  // saturated height and pixels in this page
  assign height = (num > NUM_W'(255)) ? 8'hFF : num[SMP_W-1:0];
  assign base   = SMP_W'(ROW_W'(PAGE_ROWS - 1) - row) << 3;
  assign above  = height - base;
  always_comb begin
    if (height <= base) begin
      npix = 4'd0;
    end else if (above >= SMP_W'(8)) begin
      npix = 4'd8;
    end else begin
      npix = above[3:0];
    end
  end
  assign byte_val = (draw && scale != '0) ? ~(8'hFF >> npix) : '0;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_HOLD) && (!out_valid || results.ready);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_DIV;
      ST_DIV:  if (step == STEP_W'(NUM_W - 1)) state_next = ST_HOLD;
      ST_HOLD: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      num   <= {q_head.span, H_SHIFT'(0)};
      rem   <= '0;
      scale <= q_head.scale;
      draw  <= q_head.draw;
      row   <= q_head.row;
      step  <= '0;
    end else if (state == ST_DIV) begin
      num  <= {num[NUM_W-2:0], ge};
      rem  <= ge ? SMP_W'(trial - {1'b0, scale}) : trial[SMP_W-1:0];
      step <= step + STEP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte     <= byte_val;
      out_scale_ok <= scale != '0;
    end
  end

  assign results.valid       = out_valid;
  assign results.pixel_byte  = out_byte;
  assign results.scale_valid = out_scale_ok;

endmodule

`default_nettype wire

[hw/rtl/bar_graph_page_renderer_unit.sv]
// Bar graph page renderer for a 4-page (32 pixel) monochrome display. Clear
// and load words produce no result. A read word reads the store at
// acceptance and its command is pushed once the queue has room; words are
// held off while it waits. A command queue of two entries hands it to the
// back end, whose serial divider works out 32*(sample-floor)/scale one
// quotient bit a cycle. The back end fetches a command, divides, then fills
// the result register, and fetches the next command only once the result
// register has been loaded. The front end keeps taking clear and load words
// while earlier reads are still in the divider. Configuration writes are
// taken every cycle and are meant for idle periods only.
// depends on bgpr_pkg, bgpr_if, bgpr_front, bgpr_queue, bgpr_back
`timescale 1ns / 1ps
`default_nettype none

module bar_graph_page_renderer_unit import bgpr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bgpr_in_if.sink    items,
  bgpr_cfg_if.sink   cfg,
  bgpr_out_if.source results
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  // front end
  bgpr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .cfg    (cfg),
    .q_push (q_push),
    .q_cmd  (q_cmd),
    .q_full (q_full)
  );

  // command queue
  bgpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // divider back end
  bgpr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .results (results)
  );

  // queue never written when full nor read when empty
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

  // a zero scale draws nothing
  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.scale_valid) |-> (results.pixel_byte == '0))
    else $error("pixels drawn with zero scale");

  // a pushed command reaches the queue
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_empty)
    else $error("pushed command lost");

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for bar_graph_page_renderer_unit: drives clear, load, read and unused words
// with random gaps and stalls, predicts every pixel word and checks them in order
// depends on bgpr_pkg, bgpr_if and the renderer rtl
`timescale 1ns / 1ps

module tb;
  import bgpr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS = 190;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              scale_valid;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst;

  bgpr_in_if  word_ch ();
  bgpr_cfg_if cfg_ch ();
  bgpr_out_if pix_ch ();

  bar_graph_page_renderer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (word_ch),
    .cfg     (cfg_ch),
    .results (pix_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the renderer state
  logic [SMP_W-1:0] bars [COLUMNS];
  int               bar_count = 0;
  logic [SMP_W-1:0] peak_span = '0;
  logic [SMP_W-1:0] floor_set = '0;
  logic [SMP_W-1:0] scale_set = FULL_SCALE_RST;

  pixel_word_t expected_pixels [$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  bytes_checked = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  bit  calm_send = 1'b0;
  bit  calm_take = 1'b0;

  // wait drawn per word, none while in a calm stretch
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // pixel byte of one page row of one column under the current settings
  function automatic pixel_word_t render_byte(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    pixel_word_t res;
    int unsigned span_in_use;
    int unsigned height;
    int          pixels;
    res.pixel_byte  = '0;
    res.scale_valid = 1'b0;
    span_in_use = (scale_set != 0) ? scale_set : peak_span;
    if (span_in_use == 0) return res;
    res.scale_valid = 1'b1;
    if (int'(c) < bar_count) begin
      height = 0;
      if (bars[c] > floor_set) begin
        height = (GRAPH_H * (int'(bars[c]) - int'(floor_set))) / span_in_use;
        if (height > 255) height = 255;
      end
      pixels = int'(height) - (PAGE_ROWS - 1 - int'(r)) * 8;
      if (pixels > 8) pixels = 8;
      if (pixels > 0) res.pixel_byte = 8'hFF << (8 - pixels);
    end
    return res;
  endfunction

  // update the mirror for one accepted word, queue a pixel word for reads
  task automatic advance_renderer(input op_t op, input logic [SMP_W-1:0] smp,
                                  input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    case (op)
      OP_CLEAR: begin
        bar_count = 0;
        peak_span = '0;
      end
      OP_LOAD: begin
        if (bar_count < COLUMNS) begin
          bars[bar_count] = smp;
          bar_count++;
          if (smp > floor_set && smp - floor_set > peak_span) peak_span = smp - floor_set;
        end
      end
      OP_READ: expected_pixels.push_back(render_byte(r, c));
      default: ;
    endcase
  endtask

  // send one word; valid stays up when the next word follows without a gap
  task automatic send_word(input op_t op, input logic [SMP_W-1:0] smp,
                           input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    int gap;
    gap = draw_gap(calm_send);
    if (gap > 0) begin
      word_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_ch.valid     <= 1'b1;
    word_ch.operation <= op;
    word_ch.sample    <= smp;
    word_ch.row       <= r;
    word_ch.column    <= c;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
    advance_renderer(op, smp, r, c);
    words_sent++;
  endtask

  task automatic read_byte(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    send_word(OP_READ, SMP_W'($urandom), r, c);
  endtask

  task automatic load_sample(input logic [SMP_W-1:0] smp);
    send_word(OP_LOAD, smp, ROW_W'($urandom), COL_W'($urandom));
  endtask

  // drop valid, let every pixel word come home, then let the pipe settle
  task automatic wait_idle();
    word_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_FLOOR) floor_set = val;
    else scale_set = val;
  endtask

  // only called while the block is idle
  task automatic set_registers(input logic [SMP_W-1:0] floor_v, input logic [SMP_W-1:0] scale_v);
    write_reg(CFG_FLOOR, floor_v);
    write_reg(CFG_SCALE, scale_v);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // reset settings with an empty store, plus an unused code
  task automatic test_after_reset();
    read_byte(2'd0, 7'd0);
    send_word(OP_NONE, 8'hFF, 2'd3, 7'd127);
    read_byte(2'd3, 7'd127);
  endtask

  // bar shapes across the four page rows at the reset scale
  task automatic test_bar_shapes();
    wait_idle();
    set_registers(8'd0, FULL_SCALE_RST);
    load_sample(8'd0);
    load_sample(8'd255);
    load_sample(8'd74);
    read_byte(2'd0, 7'd1);
    read_byte(2'd0, 7'd2);
    read_byte(2'd1, 7'd2);
    read_byte(2'd2, 7'd2);
    read_byte(2'd3, 7'd2);
    read_byte(2'd3, 7'd0);
    read_byte(2'd3, 7'd127);
  endtask

  // autoscale with nothing loaded, then a saturating height
  task automatic test_autoscale_and_saturation();
    wait_idle();
    set_registers(8'd0, 8'd0);
    send_word(OP_CLEAR, 8'd0, 2'd0, 7'd0);
    read_byte(2'd3, 7'd0);
    load_sample(8'd255);
    read_byte(2'd0, 7'd0);
    wait_idle();
    set_registers(8'd0, 8'd1);
    read_byte(2'd0, 7'd0);
  endtask

  // samples at and just above the floor
  task automatic test_floor_clipping();
    wait_idle();
    set_registers(8'd255, 8'd255);
    load_sample(8'd255);
    read_byte(2'd3, 7'd1);
    wait_idle();
    set_registers(8'd100, 8'd0);
    send_word(OP_CLEAR, 8'd0, 2'd0, 7'd0);
    load_sample(8'd100);
    load_sample(8'd101);
    read_byte(2'd3, 7'd0);
    read_byte(2'd3, 7'd1);
  endtask

  // random frames: usually a clear, a run of loads, then mostly reads with some noise
  task automatic run_phase(input logic [SMP_W-1:0] floor_v, input logic [SMP_W-1:0] scale_v);
    int sent;
    int loads;
    int reads;
    int pick;
    int near;
    logic [COL_W-1:0] c;
    wait_idle();
    set_registers(floor_v, scale_v);
    sent = 0;
    while (sent < PHASE_WORDS) begin
      calm_send = ($urandom_range(0, 3) == 0);
      calm_take = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_word(OP_CLEAR, SMP_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        sent++;
      end
      loads = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 24);
      reads = $urandom_range(10, 30);
      repeat (loads + reads) begin
        pick = (loads > 0) ? 20 : $urandom_range(0, 99);
        if (loads > 0) loads--;
        near = int'(floor_set) + $urandom_range(0, 8);
        if (near > 255) near = 255;
        if (pick < 3) begin
          send_word(OP_NONE, SMP_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end else if (pick < 15 || pick == 20) begin
          load_sample(($urandom_range(0, 3) == 0) ? SMP_W'(near) : SMP_W'($urandom));
        end else begin
          if (bar_count > 0 && pick >= 25) c = COL_W'($urandom_range(0, bar_count - 1));
          else c = COL_W'($urandom);
          read_byte(ROW_W'($urandom), c);
        end
        sent++;
      end
    end
    calm_send = 1'b0;
    calm_take = 1'b0;
  endtask

  task automatic test_random_settings();
    run_phase(8'd0, FULL_SCALE_RST);
    run_phase(8'd0, 8'd0);
    run_phase(8'd255, 8'd255);
    run_phase(8'd0, 8'd1);
    run_phase(8'd90, 8'd0);
    run_phase(SMP_W'($urandom), SMP_W'($urandom));
    run_phase(SMP_W'($urandom), 8'd40);
  endtask

  // stimulus
  initial begin
    rst               <= 1'b1;
    word_ch.valid     <= 1'b0;
    word_ch.operation <= OP_CLEAR;
    word_ch.sample    <= '0;
    word_ch.row       <= '0;
    word_ch.column    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_FLOOR;
    cfg_ch.data       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_bar_shapes();
    test_autoscale_and_saturation();
    test_floor_clipping();
    test_random_settings();
    wait_idle();
    $display("sent %0d words and checked %0d pixel words", words_sent, bytes_checked);
    $display("over %0d register settings, with %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // result side: random stalls, each pixel word checked against the oldest prediction
  initial begin
    pixel_word_t want;
    int stall;
    stall = 0;
    pix_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel word with none outstanding: pixel_byte %0h scale_valid %0b",
                 pix_ch.pixel_byte, pix_ch.scale_valid);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_ch.pixel_byte !== want.pixel_byte) begin
            $error("pixel_byte: expected %0h, got %0h", want.pixel_byte, pix_ch.pixel_byte);
            mismatches++;
          end
          if (pix_ch.scale_valid !== want.scale_valid) begin
            $error("scale_valid: expected %0b, got %0b", want.scale_valid, pix_ch.scale_valid);
            mismatches++;
          end
        end
        bytes_checked++;
        stall = draw_gap(calm_take);
      end
      if (stall > 0) begin
        pix_ch.ready <= 1'b0;
        stall--;
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule
